@@ rtl/nes_pkg.sv @@
// Package for the next even smooth size unit: widths, reciprocal constants,
// sequencer states, shared-unit operations and the control/status structs.
// No dependencies.
package nes_pkg;

    // Field widths.
    localparam int RES_W  = 32;                   // result width
    localparam int WANT_W = 31;                   // wanted size width
    localparam int DIV_W  = 16;                   // divisor width
    localparam int N_W    = WANT_W + 1;           // wanted size after rounding to even
    localparam int EXP_W  = $clog2(DIV_W);        // holds any prime exponent of the divisor
    localparam int CNT_W  = $clog2(RES_W) + 1;    // holds the largest power-of-three exponent
    localparam int UNIT_W = RES_W + (1 << EXP_W); // shared shift-add unit output width
    localparam int CMP_W  = (RES_W > N_W) ? RES_W : N_W;

    // Exact division of a divisor-wide value by 3 and by 5 via reciprocal multiply.
    localparam int RCP_W   = 2 * DIV_W + 2;
    localparam int RCP3_SH = 17;
    localparam int RCP5_SH = 18;
    localparam logic [RCP_W-1:0] RCP3 = RCP_W'(43691);
    localparam logic [RCP_W-1:0] RCP5 = RCP_W'(52429);

    localparam logic [RES_W-1:0] SMALL_RESULT = RES_W'(2);
    localparam logic [N_W-1:0]   SMALL_LIMIT  = N_W'(2);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FAC2,
        ST_FAC3,
        ST_FAC5,
        ST_OUTER,
        ST_INNER,
        ST_SHIFT,
        ST_DOUBLE,
        ST_NEXT5,
        ST_NEXT3,
        ST_FIN,
        ST_DONE
    } nes_state_t;

    typedef enum logic [1:0] {
        UOP_MUL3,
        UOP_MUL5,
        UOP_SHIFT,
        UOP_DOUBLE
    } nes_uop_t;

    typedef struct packed {
        logic     start;
        nes_uop_t uop;
        logic     fac2_step;
        logic     fac3_step;
        logic     fac5_step;
        logic     search_init;
        logic     fail_load;
        logic     q_init;
        logic     v_load;
        logic     best_update;
        logic     q_step;
        logic     p3_step;
        logic     fin;
        logic     out_load;
    } nes_ctrl_t;

    typedef struct packed {
        logic small_n;
        logic b_zero;
        logic rest_odd;
        logic div3_ok;
        logic div5_ok;
        logic rest_is_one;
        logic c_ge_e3;
        logic d_ge_e5;
        logic unit_ovf;
        logic v_ge_n;
        logic v_worse;
    } nes_stat_t;

endpackage

@@ rtl/nes_if.sv @@
// Request and response channel interfaces of the next even smooth size unit.
// Depends on nes_pkg for the field widths.
interface nes_req_if import nes_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WANT_W-1:0] wanted_size;
    logic [DIV_W-1:0]  multiple_of;

    modport source (output valid, output wanted_size, output multiple_of, input ready);
    modport sink   (input valid, input wanted_size, input multiple_of, output ready);
endinterface

interface nes_rsp_if import nes_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RES_W-1:0] smooth_size;
    logic             error;

    modport source (output valid, output smooth_size, output error, input ready);
    modport sink   (input valid, input smooth_size, input error, output ready);
endinterface

@@ rtl/nes_dpath.sv @@
// Datapath of the next even smooth size unit: divisor factoring, candidate
// registers and the shared shift-add unit. Depends on nes_pkg.
module nes_dpath import nes_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [WANT_W-1:0] wanted_size,
    input  logic [DIV_W-1:0]  multiple_of,
    input  nes_ctrl_t         ctrl,
    output nes_stat_t         status,
    output logic [RES_W-1:0]  res_size,
    output logic              res_err
);

    logic [N_W-1:0]   n_reg,    n_next;
    logic [DIV_W-1:0] rest_reg, rest_next;
    logic [EXP_W-1:0] e2_reg,   e2_next;
    logic [EXP_W-1:0] e3_reg,   e3_next;
    logic [EXP_W-1:0] e5_reg,   e5_next;
    logic [RES_W-1:0] p3_reg,   p3_next;
    logic [RES_W-1:0] q_reg,    q_next;
    logic [RES_W-1:0] v_reg,    v_next;
    logic [RES_W-1:0] best_reg, best_next;
    logic [CNT_W-1:0] c_reg,    c_next;
    logic [CNT_W-1:0] d_reg,    d_next;
    logic             found_reg, found_next;
    logic [RES_W-1:0] res_reg,  res_next;
    logic             err_reg,  err_next;

    logic [RCP_W-1:0] prod3, prod5;
    logic [DIV_W-1:0] quo3, quo5;
    logic [DIV_W+2:0] back3, back5;

    logic [RES_W-1:0]  ux;
    logic [EXP_W-1:0]  ush;
    logic              uadd;
    logic [UNIT_W-1:0] uy;

    // Exact quotients by 3 and 5; multiplying back tells whether the division was exact.
    assign prod3 = RCP_W'(rest_reg) * RCP3;
    assign prod5 = RCP_W'(rest_reg) * RCP5;
    assign quo3  = prod3[RCP3_SH +: DIV_W];
    assign quo5  = prod5[RCP5_SH +: DIV_W];
    assign back3 = (DIV_W+3)'({quo3, 1'b0}) + (DIV_W+3)'(quo3);
    assign back5 = (DIV_W+3)'({quo5, 2'b00}) + (DIV_W+3)'(quo5);

    // Shared shift-add unit: times three, times five, shift by the power of two, double.
    always_comb
    begin
        unique case (ctrl.uop)
            UOP_MUL3:
            begin
                ux = p3_reg;
                ush = EXP_W'(1);
                uadd = 1'b1;
            end
            UOP_MUL5:
            begin
                ux = q_reg;
                ush = EXP_W'(2);
                uadd = 1'b1;
            end
            UOP_SHIFT:
            begin
                ux = q_reg;
                ush = e2_reg;
                uadd = 1'b0;
            end
            UOP_DOUBLE:
            begin
                ux = v_reg;
                ush = EXP_W'(1);
                uadd = 1'b0;
            end
            default:
            begin
                ux = p3_reg;
                ush = EXP_W'(1);
                uadd = 1'b0;
            end
        endcase
    end

    assign uy = (UNIT_W'(ux) << ush) + (uadd ? UNIT_W'(ux) : '0);

    always_comb
    begin
        status.small_n     = (N_W'(wanted_size) <= SMALL_LIMIT);
        status.b_zero      = (multiple_of == '0);
        status.rest_odd    = rest_reg[0];
        status.div3_ok     = (back3 == (DIV_W+3)'(rest_reg));
        status.div5_ok     = (back5 == (DIV_W+3)'(rest_reg));
        status.rest_is_one = (rest_reg == DIV_W'(1));
        status.c_ge_e3     = (c_reg >= CNT_W'(e3_reg));
        status.d_ge_e5     = (d_reg >= CNT_W'(e5_reg));
        status.unit_ovf    = |uy[UNIT_W-1:RES_W];
        status.v_ge_n      = (CMP_W'(v_reg) >= CMP_W'(n_reg));
        status.v_worse     = found_reg && (v_reg >= best_reg);
    end

    always_comb
    begin
        n_next     = n_reg;
        rest_next  = rest_reg;
        e2_next    = e2_reg;
        e3_next    = e3_reg;
        e5_next    = e5_reg;
        p3_next    = p3_reg;
        q_next     = q_reg;
        v_next     = v_reg;
        best_next  = best_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        found_next = found_reg;
        res_next   = res_reg;
        err_next   = err_reg;

        if (ctrl.start)
        begin
            n_next    = N_W'(wanted_size) + N_W'(wanted_size[0]);
            rest_next = multiple_of;
            e2_next   = '0;
            e3_next   = '0;
            e5_next   = '0;
            res_next  = status.small_n ? SMALL_RESULT : '0;
            err_next  = !status.small_n;
        end
        if (ctrl.fac2_step)
        begin
            rest_next = rest_reg >> 1;
            e2_next   = e2_reg + EXP_W'(1);
        end
        if (ctrl.fac3_step)
        begin
            rest_next = quo3;
            e3_next   = e3_reg + EXP_W'(1);
        end
        if (ctrl.fac5_step)
        begin
            rest_next = quo5;
            e5_next   = e5_reg + EXP_W'(1);
        end
        if (ctrl.fail_load)
        begin
            res_next = '0;
            err_next = 1'b1;
        end
        if (ctrl.search_init)
        begin
            // The result must be even, so at least one factor of two.
            e2_next    = (e2_reg == '0) ? EXP_W'(1) : e2_reg;
            p3_next    = RES_W'(1);
            c_next     = '0;
            found_next = 1'b0;
        end
        if (ctrl.q_init)
        begin
            q_next = p3_reg;
            d_next = '0;
        end
        if (ctrl.v_load)
        begin
            v_next = uy[RES_W-1:0];
        end
        if (ctrl.best_update)
        begin
            best_next  = v_reg;
            found_next = 1'b1;
        end
        if (ctrl.q_step)
        begin
            q_next = uy[RES_W-1:0];
            d_next = d_reg + CNT_W'(1);
        end
        if (ctrl.p3_step)
        begin
            p3_next = uy[RES_W-1:0];
            c_next  = c_reg + CNT_W'(1);
        end
        if (ctrl.fin)
        begin
            res_next = found_reg ? best_reg : '0;
            err_next = !found_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        rest_reg <= rest_next;
        e2_reg   <= e2_next;
        e3_reg   <= e3_next;
        e5_reg   <= e5_next;
        p3_reg   <= p3_next;
        q_reg    <= q_next;
        v_reg    <= v_next;
        best_reg <= best_next;
        c_reg    <= c_next;
        d_reg    <= d_next;
        res_reg  <= res_next;
        err_reg  <= err_next;
    end

    assign res_size = res_reg;
    assign res_err  = err_reg;

endmodule

@@ rtl/nes_ctrl.sv @@
// Sequencer of the next even smooth size unit: steps factoring and the
// candidate search over the shared unit. Depends on nes_pkg.
module nes_ctrl import nes_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      out_free,
    input  nes_stat_t status,
    output logic      in_ready,
    output nes_ctrl_t ctrl
);

    nes_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (status.small_n || status.b_zero) ? ST_DONE : ST_FAC2;
                end
            end
            ST_FAC2:
            begin
                if (status.rest_odd)
                begin
                    state_next = ST_FAC3;
                end
            end
            ST_FAC3:
            begin
                if (!status.div3_ok)
                begin
                    state_next = ST_FAC5;
                end
            end
            ST_FAC5:
            begin
                if (!status.div5_ok)
                begin
                    state_next = status.rest_is_one ? ST_OUTER : ST_DONE;
                end
            end
            ST_OUTER:  state_next = status.c_ge_e3 ? ST_INNER : ST_NEXT3;
            ST_INNER:  state_next = status.d_ge_e5 ? ST_SHIFT : ST_NEXT5;
            ST_SHIFT:  state_next = status.unit_ovf ? ST_NEXT5 : ST_DOUBLE;
            ST_DOUBLE:
            begin
                if (status.v_ge_n || status.v_worse || status.unit_ovf)
                begin
                    state_next = ST_NEXT5;
                end
            end
            ST_NEXT5:  state_next = status.unit_ovf ? ST_NEXT3 : ST_INNER;
            ST_NEXT3:  state_next = status.unit_ovf ? ST_FIN : ST_OUTER;
            ST_FIN:    state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        ctrl.uop = UOP_MUL3;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                ctrl.start = in_valid;
            end
            ST_FAC2:   ctrl.fac2_step = !status.rest_odd;
            ST_FAC3:   ctrl.fac3_step = status.div3_ok;
            ST_FAC5:
            begin
                ctrl.fac5_step   = status.div5_ok;
                ctrl.search_init = !status.div5_ok && status.rest_is_one;
                ctrl.fail_load   = !status.div5_ok && !status.rest_is_one;
            end
            ST_OUTER:  ctrl.q_init = status.c_ge_e3;
            ST_INNER:  ctrl = ctrl;
            ST_SHIFT:
            begin
                ctrl.uop    = UOP_SHIFT;
                ctrl.v_load = !status.unit_ovf;
            end
            ST_DOUBLE:
            begin
                ctrl.uop         = UOP_DOUBLE;
                ctrl.best_update = status.v_ge_n && !status.v_worse;
                ctrl.v_load      = !status.v_ge_n && !status.v_worse && !status.unit_ovf;
            end
            ST_NEXT5:
            begin
                ctrl.uop    = UOP_MUL5;
                ctrl.q_step = !status.unit_ovf;
            end
            ST_NEXT3:
            begin
                ctrl.uop     = UOP_MUL3;
                ctrl.p3_step = !status.unit_ovf;
            end
            ST_FIN:    ctrl.fin = 1'b1;
            ST_DONE:   ctrl.out_load = out_free;
            default:   ctrl = '0;
        endcase
    end

endmodule

@@ rtl/next_even_smooth_size_unit.sv @@
// Top level of the next even smooth size unit: sequencer, datapath and the
// output register. Depends on nes_pkg, nes_if, nes_ctrl and nes_dpath.
//
// Each request item carries a wanted size and a divisor; the response item is
// the smallest even number, not below the wanted size, that has no prime factor
// above 5 and is a multiple of the divisor. A wanted size of 2 or less answers
// 2 whatever the divisor. A zero divisor, a divisor with a prime factor above
// 5, or an answer that does not fit in 32 bits answers 0 with the error flag
// set. The unit takes one item at a time and holds req.ready low from acceptance
// until the result has moved into the output register. A small wanted size or a
// zero divisor goes straight to the done state, from which its result moves
// into the output register as soon as that register is free; the next item can
// then be taken. Otherwise the divisor is factored one prime factor per cycle,
// first twos, then threes, then fives; a divisor that is not 5-smooth ends
// right there. For a 5-smooth divisor the search then walks the products of a
// power of three and a power of five that fit in 32 bits (about 157 of them),
// trying only those that hold the divisor's powers of three and five; each
// power of three is stepped in the NEXT3 state and checked in the OUTER state.
// Each product passes through one shared shift-add unit: it is shifted by the
// power of two, doubled toward the wanted size and then multiplied by five, or
// only multiplied by five when the divisor's power of five is not yet reached,
// with doubling cut short as soon as a candidate can no longer beat the best
// one found. The output register lets the next item be accepted while a result
// waits.
module next_even_smooth_size_unit import nes_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    nes_req_if.sink   req,
    nes_rsp_if.source rsp
);

    nes_ctrl_t        ctrl;
    nes_stat_t        status;
    logic [RES_W-1:0] res_size;
    logic             res_err;
    logic             out_free;

    logic             out_valid_reg, out_valid_next;
    logic [RES_W-1:0] out_size_reg,  out_size_next;
    logic             out_err_reg,   out_err_next;

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || rsp.ready;

    nes_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .out_free (out_free),
        .status   (status),
        .in_ready (req.ready),
        .ctrl     (ctrl)
    );

    nes_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .wanted_size (req.wanted_size),
        .multiple_of (req.multiple_of),
        .ctrl        (ctrl),
        .status      (status),
        .res_size    (res_size),
        .res_err     (res_err)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_size_next  = out_size_reg;
        out_err_next   = out_err_reg;
        if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
            out_size_next  = res_size;
            out_err_next   = res_err;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_size_reg <= out_size_next;
        out_err_reg  <= out_err_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.smooth_size = out_size_reg;
    assign rsp.error       = out_err_reg;

    // An error result always carries a zero size.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.error |-> rsp.smooth_size == '0)
        else $error("error result with nonzero size");

    // A good result is even and nonzero.
    a_good_even: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.error |-> !rsp.smooth_size[0] && rsp.smooth_size != '0)
        else $error("good result is odd or zero");

    // The unit is busy in the cycle after it accepts an item.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("ready right after an accepted item");

endmodule
